// ===== design/grid_ray_cell_traversal_top_defines.svh =====
// assertion macros for the grid ray cell traversal block
// used by the controller and datapath files, no other dependencies
`ifndef GRID_RAY_CELL_TRAVERSAL_TOP_DEFINES_SVH
`define GRID_RAY_CELL_TRAVERSAL_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grt assertion failed");

// next-cycle implication, disabled during reset
`define GRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grt assertion failed");

`endif

// ===== design/grt_pkg.sv =====
// shared constants, item structs and control structs for the grid ray traversal
// no dependencies
`default_nettype none

package grt_pkg;

    localparam int GRID_CELLS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int POS_W  = 13;
    localparam int CELL_W = 5;
    localparam int T_W    = 18;
    localparam int T_FRAC = 16;

    localparam logic [T_W-1:0] T_ONE = 18'h10000;
    localparam logic [T_W-1:0] T_MAX = 18'h3FFFF;

    localparam logic [CELL_W-1:0] STEP_UP   = 5'h01;
    localparam logic [CELL_W-1:0] STEP_DOWN = 5'h1F;
    localparam logic [CELL_W-1:0] STEP_NONE = 5'h00;

    typedef struct packed {
        logic [POS_W-1:0] ray_start_x;
        logic [POS_W-1:0] ray_start_y;
        logic [POS_W-1:0] ray_end_x;
        logic [POS_W-1:0] ray_end_y;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0] cell_col;
        logic [CELL_W-1:0] cell_row;
        logic              last_cell;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step_div;
        logic take;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic cur_ok;
        logic last;
    } t_status;

endpackage

`default_nettype wire

// ===== design/grt_div.sv =====
// iterative restoring divider, one quotient bit per step, saturated result
// depends on grt_pkg
`default_nettype none

module grt_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 13
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_load,
    input  wire logic                    i_step,
    input  wire logic [NUM_W-1:0]        i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    output logic [grt_pkg::T_W-1:0]      o_quot
);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (i_step) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    assign o_quot = (r_quot > NUM_W'(grt_pkg::T_MAX)) ? grt_pkg::T_MAX
                                                       : r_quot[grt_pkg::T_W-1:0];

endmodule

`default_nettype wire

// ===== design/grt_datapath.sv =====
// datapath: axis set-up, four dividers, traversal registers and output register
// depends on grt_pkg, grt_div and the assertion macro header
`default_nettype none
`include "grid_ray_cell_traversal_top_defines.svh"

module grt_datapath #(
    parameter int GRID_CELLS = grt_pkg::GRID_CELLS_DEF,
    parameter int FRAC_BITS  = grt_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire grt_pkg::t_cmd     i_cmd,
    output grt_pkg::t_status       o_status,
    input  wire grt_pkg::t_in_item i_in_item,
    output grt_pkg::t_out_item     o_out_item
);

    localparam int POS_W  = grt_pkg::POS_W;
    localparam int CELL_W = grt_pkg::CELL_W;
    localparam int T_W    = grt_pkg::T_W;
    localparam int DIST_W = FRAC_BITS + 1;
    localparam int NUM_W  = DIST_W + grt_pkg::T_FRAC;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int N_W    = $clog2(2 * GRID_CELLS);

    localparam logic [N_W-1:0]    MAX_N      = N_W'(2 * GRID_CELLS - 1);
    localparam logic [N_W-1:0]    MAX_N_LESS = N_W'(2 * GRID_CELLS - 2);
    localparam logic [POS_W-1:0]  FMASK      = POS_W'((64'(1) << FRAC_BITS) - 64'(1));
    localparam logic [DIST_W-1:0] DIST_ONE   = DIST_W'(64'(1) << FRAC_BITS);
    localparam logic [NUM_W-1:0]  NUM_TD     = NUM_W'(1) << (FRAC_BITS + grt_pkg::T_FRAC);

    // axis set-up from the incoming item
    logic [POS_W-1:0]  sx, sy, ex, ey;
    logic [POS_W-1:0]  mag_x, mag_y;
    logic [POS_W-1:0]  frac_x, frac_y;
    logic [DIST_W-1:0] dist_x, dist_y;
    logic [CELL_W-1:0] step_x, step_y;
    logic [NUM_W-1:0]  num_x, num_y;

    assign sx = i_in_item.ray_start_x;
    assign sy = i_in_item.ray_start_y;
    assign ex = i_in_item.ray_end_x;
    assign ey = i_in_item.ray_end_y;

    assign frac_x = sx & FMASK;
    assign frac_y = sy & FMASK;

    always_comb begin
        priority if (ex > sx) begin
            mag_x  = ex - sx;
            dist_x = DIST_ONE - DIST_W'(frac_x);
            step_x = grt_pkg::STEP_UP;
        end else if (ex < sx) begin
            mag_x  = sx - ex;
            dist_x = DIST_W'(frac_x);
            step_x = grt_pkg::STEP_DOWN;
        end else begin
            mag_x  = '0;
            dist_x = '0;
            step_x = grt_pkg::STEP_NONE;
        end
        priority if (ey > sy) begin
            mag_y  = ey - sy;
            dist_y = DIST_ONE - DIST_W'(frac_y);
            step_y = grt_pkg::STEP_UP;
        end else if (ey < sy) begin
            mag_y  = sy - ey;
            dist_y = DIST_W'(frac_y);
            step_y = grt_pkg::STEP_DOWN;
        end else begin
            mag_y  = '0;
            dist_y = '0;
            step_y = grt_pkg::STEP_NONE;
        end
    end

    assign num_x = {dist_x, {grt_pkg::T_FRAC{1'b0}}};
    assign num_y = {dist_y, {grt_pkg::T_FRAC{1'b0}}};

    // dividers
    logic [T_W-1:0] q_tdx, q_tx, q_tdy, q_ty;

    grt_div #(.NUM_W(NUM_W), .DEN_W(POS_W)) u_div_tdx (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_step (i_cmd.step_div),
        .i_num  (NUM_TD),
        .i_den  (mag_x),
        .o_quot (q_tdx)
    );

    grt_div #(.NUM_W(NUM_W), .DEN_W(POS_W)) u_div_tx (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_step (i_cmd.step_div),
        .i_num  (num_x),
        .i_den  (mag_x),
        .o_quot (q_tx)
    );

    grt_div #(.NUM_W(NUM_W), .DEN_W(POS_W)) u_div_tdy (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_step (i_cmd.step_div),
        .i_num  (NUM_TD),
        .i_den  (mag_y),
        .o_quot (q_tdy)
    );

    grt_div #(.NUM_W(NUM_W), .DEN_W(POS_W)) u_div_ty (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_step (i_cmd.step_div),
        .i_num  (num_y),
        .i_den  (mag_y),
        .o_quot (q_ty)
    );

    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (i_cmd.step_div) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // traversal state
    logic [CELL_W-1:0] r_cx, r_cy, r_sx, r_sy;
    logic [T_W-1:0]    r_tx, r_ty, r_tdx, r_tdy;
    logic [N_W-1:0]    r_n;
    grt_pkg::t_out_item r_out;

    logic           x_adv;
    logic [T_W:0]   sum_x, sum_y;
    logic [T_W-1:0] nx, ny, tx_n, ty_n;
    logic           cur_ok, nxt_ok;

    assign x_adv = r_tx < r_ty;
    assign sum_x = {1'b0, r_tx} + {1'b0, r_tdx};
    assign sum_y = {1'b0, r_ty} + {1'b0, r_tdy};
    assign nx    = (sum_x > {1'b0, grt_pkg::T_MAX}) ? grt_pkg::T_MAX : sum_x[T_W-1:0];
    assign ny    = (sum_y > {1'b0, grt_pkg::T_MAX}) ? grt_pkg::T_MAX : sum_y[T_W-1:0];
    assign tx_n  = x_adv ? nx : r_tx;
    assign ty_n  = x_adv ? r_ty : ny;

    assign cur_ok = (r_tx <= grt_pkg::T_ONE || r_ty <= grt_pkg::T_ONE) && (r_n < MAX_N);
    assign nxt_ok = (tx_n <= grt_pkg::T_ONE || ty_n <= grt_pkg::T_ONE) && (r_n < MAX_N_LESS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= CELL_W'(sx >> FRAC_BITS);
            r_cy <= CELL_W'(sy >> FRAC_BITS);
            r_sx <= step_x;
            r_sy <= step_y;
        end else if (i_cmd.take) begin
            r_tx  <= q_tx;
            r_ty  <= q_ty;
            r_tdx <= q_tdx;
            r_tdy <= q_tdy;
        end else if (i_cmd.emit) begin
            r_out.cell_col  <= r_cx;
            r_out.cell_row  <= r_cy;
            r_out.last_cell <= !nxt_ok;
            r_tx <= tx_n;
            r_ty <= ty_n;
            if (x_adv) begin
                r_cx <= r_cx + r_sx;
            end else begin
                r_cy <= r_cy + r_sy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cmd.take) begin
            r_n <= '0;
        end else if (i_cmd.emit) begin
            r_n <= r_n + 1'b1;
        end
    end

    assign o_status.div_done = r_cnt == '0;
    assign o_status.cur_ok   = cur_ok;
    assign o_status.last     = !nxt_ok;
    assign o_out_item        = r_out;

    `GRT_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_n <= MAX_N)
    `GRT_ASSERT_NEXT(a_lookahead, i_clk, i_rst_n, i_cmd.emit && !o_status.last, o_status.cur_ok)

endmodule

`default_nettype wire

// ===== design/grt_ctrl.sv =====
// controller: idle, divide and walk sequencing plus output valid flag
// depends on grt_pkg and the assertion macro header
`default_nettype none
`include "grid_ray_cell_traversal_top_defines.svh"

module grt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output grt_pkg::t_cmd         o_cmd,
    input  wire grt_pkg::t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   room;

    assign room = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_WALK;
                end else begin
                    o_cmd.step_div = 1'b1;
                end
            end
            S_WALK: begin
                if (room) begin
                    if (i_status.cur_ok) begin
                        o_cmd.emit = 1'b1;
                        if (i_status.last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

    `GRT_ASSERT_IMPL(a_emit_room, i_clk, i_rst_n, o_cmd.emit, r_state == S_WALK && room)
    `GRT_ASSERT_NEXT(a_last_exit, i_clk, i_rst_n, o_cmd.emit && i_status.last, r_state == S_IDLE && r_out_valid)
    `GRT_ASSERT_NEXT(a_div_quiet, i_clk, i_rst_n, r_state == S_DIV, !$rose(r_out_valid))

endmodule

`default_nettype wire

// ===== design/grid_ray_cell_traversal_top.sv =====
// top level of the grid ray cell traversal block
// depends on grt_pkg, grt_ctrl and grt_datapath
//
// input channel: one item is a ray segment, start and end points in unsigned
// fixed point grid units; it is taken when i_in_valid is high and o_in_stall
// is low. o_in_stall is low only while the block is idle.
// output channel: one item per crossed cell (column, row, last_cell flag),
// taken when o_out_valid is high and i_out_stall is low. the cell holding the
// end point is not sent, and a ray that stays inside one cell sends nothing.
// sequence: an accept loads four iterative dividers of FRAC_BITS+17 quotient
// bits (25 by default) that run in parallel, their results then move into the
// walk registers, and then one cell leaves per cycle while the output is not
// stalled. a ray sends at most 2*GRID_CELLS-1 cells. the next ray is accepted
// as soon as the last cell of the previous ray sits in the output register.
// reset: returns to idle and drops o_out_valid; nothing is kept between rays.
// stall: while i_out_stall holds a waiting cell, the walk pauses in place.
`default_nettype none

module grid_ray_cell_traversal_top #(
    parameter int GRID_CELLS = grt_pkg::GRID_CELLS_DEF,
    parameter int FRAC_BITS  = grt_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire grt_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output grt_pkg::t_out_item     o_out_item
);

    grt_pkg::t_cmd    cmd;
    grt_pkg::t_status status;

    grt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    grt_datapath #(
        .GRID_CELLS (GRID_CELLS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

// ===== tb/grt_traversal_checker.sv =====
// scoreboard for grid_ray_cell_traversal_top: watches both channels, predicts the
// cells each accepted ray crosses and compares every output item against them
// depends on grt_pkg
module grt_traversal_checker
    import grt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_rays,
    output int        o_cells,
    output int        o_empty_rays,
    output int        o_capped_rays
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;
    localparam int MAX_CELLS = 2 * GRID_CELLS_DEF - 1;
    localparam logic [POS_W-1:0] FRAC_MASK = POS_W'((1 << FB) - 1);

    typedef struct {
        logic [CELL_W-1:0] idx;
        logic [CELL_W-1:0] step;
        logic [T_W-1:0]    t;
        logic [T_W-1:0]    dt;
    } t_axis_walk;

    t_out_item expected_cells[$];

    function automatic logic [T_W-1:0] sat_quot(input logic [31:0] num,
                                                 input logic [31:0] den);
        logic [31:0] q;
        if (den == 0)
            return T_MAX;
        q = num / den;
        return (q > 32'(T_MAX)) ? T_MAX : q[T_W-1:0];
    endfunction

    function automatic t_axis_walk axis_init(input logic [POS_W-1:0] s,
                                             input logic [POS_W-1:0] e);
        t_axis_walk w;
        logic [31:0] mag;
        logic [31:0] gap;
        mag = 0;
        gap = 0;
        w.idx = s[FB +: CELL_W];
        w.step = STEP_NONE;
        if (e > s) begin
            mag = 32'(e - s);
            gap = (32'd1 << FB) - 32'(s & FRAC_MASK);
            w.step = STEP_UP;
        end else if (e < s) begin
            mag = 32'(s - e);
            gap = 32'(s & FRAC_MASK);
            w.step = STEP_DOWN;
        end
        w.dt = sat_quot(32'd1 << (FB + T_FRAC), mag);
        w.t = sat_quot(gap << T_FRAC, mag);
        return w;
    endfunction

    function automatic void axis_advance(inout t_axis_walk w);
        logic [T_W:0] sum;
        sum = {1'b0, w.t} + {1'b0, w.dt};
        w.t = sum[T_W] ? T_MAX : sum[T_W-1:0];
        w.idx = w.idx + w.step;
    endfunction

    function automatic int trace_ray_cells(input t_in_item ray);
        t_axis_walk wx;
        t_axis_walk wy;
        t_out_item hit;
        int n;
        wx = axis_init(ray.ray_start_x, ray.ray_end_x);
        wy = axis_init(ray.ray_start_y, ray.ray_end_y);
        n = 0;
        while ((wx.t <= T_ONE || wy.t <= T_ONE) && n < MAX_CELLS) begin
            hit.cell_col = wx.idx;
            hit.cell_row = wy.idx;
            hit.last_cell = 1'b0;
            expected_cells.push_back(hit);
            n++;
            // ties go to the row axis
            if (wx.t < wy.t)
                axis_advance(wx);
            else
                axis_advance(wy);
        end
        if (n > 0) begin
            hit = expected_cells.pop_back();
            hit.last_cell = 1'b1;
            expected_cells.push_back(hit);
        end
        return n;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        int n;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                o_cells++;
                if (expected_cells.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected item, expected none, got col %0d row %0d last %0b",
                             $time, i_out_item.cell_col, i_out_item.cell_row,
                             i_out_item.last_cell);
                end else begin
                    want = expected_cells.pop_front();
                    if (i_out_item.cell_col !== want.cell_col
                            || i_out_item.cell_row !== want.cell_row
                            || i_out_item.last_cell !== want.last_cell) begin
                        o_fail_count++;
                        $display("%0t: mismatch, expected col %0d row %0d last %0b,",
                                 $time, want.cell_col, want.cell_row, want.last_cell,
                                 " got col %0d row %0d last %0b",
                                 i_out_item.cell_col, i_out_item.cell_row,
                                 i_out_item.last_cell);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_rays++;
                n = trace_ray_cells(i_in_item);
                if (n == 0)
                    o_empty_rays++;
                if (n == MAX_CELLS)
                    o_capped_rays++;
            end
        end
        o_pending = expected_cells.size();
    end

endmodule

// ===== tb/grid_ray_cell_traversal_top_tb.sv =====
// testbench top for grid_ray_cell_traversal_top: drives directed and random ray
// segments under several idle and stall patterns and reports the verdict
// depends on grt_pkg, grid_ray_cell_traversal_top and grt_traversal_checker
module grid_ray_cell_traversal_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grt_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int RUN_LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES = 600;
    localparam int RAYS_PER_PHASE = 90;
    localparam int POS_MAX = (1 << POS_W) - 1;
    localparam int FB = FRAC_BITS_DEF;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    int   idle_pct = 0;
    int   stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    int fail_count;
    int cells_pending;
    int rays_seen;
    int cells_seen;
    int empty_rays;
    int capped_rays;

    grid_ray_cell_traversal_top uut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .o_in_stall,
        .i_in_item,
        .o_out_valid,
        .i_out_stall,
        .o_out_item
    );

    grt_traversal_checker cell_check (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .i_in_stall    (o_in_stall),
        .i_in_item,
        .i_out_valid   (o_out_valid),
        .i_out_stall,
        .i_out_item    (o_out_item),
        .o_fail_count  (fail_count),
        .o_pending     (cells_pending),
        .o_rays        (rays_seen),
        .o_cells       (cells_seen),
        .o_empty_rays  (empty_rays),
        .o_capped_rays (capped_rays)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_in_item ray_of(input int sx, input int sy, input int ex, input int ey);
        t_in_item r;
        r.ray_start_x = POS_W'(sx);
        r.ray_start_y = POS_W'(sy);
        r.ray_end_x = POS_W'(ex);
        r.ray_end_y = POS_W'(ey);
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_edge(input logic [POS_W-1:0] v);
        if ($urandom_range(1) == 0)
            return v;
        return $urandom_range(1) ? POS_W'(POS_MAX) : '0;
    endfunction

    function automatic t_in_item make_ray();
        t_in_item r;
        logic [POS_W-1:0] d;
        r = ray_of($urandom_range(POS_MAX), $urandom_range(POS_MAX),
                   $urandom_range(POS_MAX), $urandom_range(POS_MAX));
        case ($urandom_range(9))
            3, 4: begin
                r.ray_end_x = r.ray_start_x + POS_W'($urandom_range(1536)) - POS_W'(768);
                r.ray_end_y = r.ray_start_y + POS_W'($urandom_range(1536)) - POS_W'(768);
            end
            5: begin
                if ($urandom_range(1))
                    r.ray_end_y = r.ray_start_y;
                else
                    r.ray_end_x = r.ray_start_x;
            end
            6: begin
                r.ray_start_x[FB-1:0] = '0;
                r.ray_start_y[FB-1:0] = '0;
                if ($urandom_range(1)) begin
                    r.ray_end_x[FB-1:0] = '0;
                    r.ray_end_y[FB-1:0] = '0;
                end
            end
            7: begin
                d = POS_W'($urandom_range(2048));
                r.ray_end_x = $urandom_range(1) ? r.ray_start_x + d : r.ray_start_x - d;
                r.ray_end_y = $urandom_range(1) ? r.ray_start_y + d : r.ray_start_y - d;
            end
            8: begin
                r.ray_end_x = r.ray_start_x + POS_W'($urandom_range(6)) - POS_W'(3);
                r.ray_end_y = r.ray_start_y + POS_W'($urandom_range(6)) - POS_W'(3);
            end
            9: begin
                r.ray_start_x = pick_edge(r.ray_start_x);
                r.ray_start_y = pick_edge(r.ray_start_y);
                r.ray_end_x = pick_edge(r.ray_end_x);
                r.ray_end_y = pick_edge(r.ray_end_y);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_ray(input t_in_item ray);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= ray;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length and single cell rays
        send_ray(ray_of(13'h0000, 13'h0000, 13'h0000, 13'h0000));
        send_ray(ray_of(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF));
        send_ray(ray_of(13'h0140, 13'h0140, 13'h01C0, 13'h01A0));
        // axis aligned, in both directions, from integer and half-cell starts
        send_ray(ray_of(13'h0100, 13'h0100, 13'h0500, 13'h0100));
        send_ray(ray_of(13'h0500, 13'h0100, 13'h0100, 13'h0100));
        send_ray(ray_of(13'h0180, 13'h0080, 13'h0180, 13'h0880));
        send_ray(ray_of(13'h0180, 13'h0880, 13'h0180, 13'h0080));
        // exact diagonals hit ties at every corner
        send_ray(ray_of(13'h0080, 13'h0080, 13'h0380, 13'h0380));
        send_ray(ray_of(13'h0380, 13'h0380, 13'h0080, 13'h0080));
        // corner to corner, long enough for the cell limit
        send_ray(ray_of(13'h0000, 13'h0000, 13'h1FFF, 13'h1FFF));
        send_ray(ray_of(13'h1FFF, 13'h1FFF, 13'h0000, 13'h0000));
        send_ray(ray_of(13'h0000, 13'h1FFF, 13'h1FFF, 13'h0000));
        send_ray(ray_of(13'h1FFF, 13'h0000, 13'h0000, 13'h1FFF));
        // one lsb of travel saturates the increment
        send_ray(ray_of(13'h01FF, 13'h0100, 13'h0200, 13'h0100));
        send_ray(ray_of(13'h0200, 13'h0100, 13'h01FF, 13'h0100));
        // indexes wrapping below zero
        send_ray(ray_of(13'h0100, 13'h0000, 13'h0000, 13'h1FFF));
        send_ray(ray_of(13'h0000, 13'h0100, 13'h1FFF, 13'h0000));
        send_ray(ray_of(13'h00FF, 13'h00FF, 13'h0101, 13'h0101));
        send_ray(ray_of(13'h0123, 13'h1F00, 13'h1E45, 13'h00A7));
        send_ray(ray_of(13'h0000, 13'h0000, 13'h1FFF, 13'h0001));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    hold_req <= 1'b1;
                end
                1: begin
                    idle_pct = 82;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 82;
                end
                default: begin
                    idle_pct = 16;
                    stall_pct <= 16;
                end
            endcase
            repeat (RAYS_PER_PHASE) send_ray(make_ray());
        end

        i_in_valid <= 1'b0;
        stall_pct <= 0;
        do @(negedge i_clk); while (cells_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d rays and %0d cells under four idle and stall patterns",
                 rays_seen, cells_seen);
        $display("%0d rays crossed no boundary, %0d ran into the cell limit",
                 empty_rays, capped_rays);
        if (fail_count == 0)
            $display("grid_ray_cell_traversal_top verification clean");
        else
            $display("grid_ray_cell_traversal_top verification failed");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
        $display("grid_ray_cell_traversal_top verification failed");
        $finish;
    end

endmodule

// ===== grid_ray_cell_traversal_top.f =====
+incdir+design
design/grt_pkg.sv
design/grt_div.sv
design/grt_datapath.sv
design/grt_ctrl.sv
design/grid_ray_cell_traversal_top.sv
tb/grt_traversal_checker.sv
tb/grid_ray_cell_traversal_top_tb.sv
